/* src/prpic_pkg.sv */
// Shared constants and types for the period-to-rpm integral PWM controller.
package prpic_pkg;

    localparam int PERIOD_W = 8;
    localparam int RPM_W    = 14;
    localparam int DUTY_W   = 8;
    localparam int STEP_W   = 4;

    // serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = RPM_W;

    localparam logic [RPM_W-1:0]    SPEED_NUM    = 14'd14000;
    localparam logic [PERIOD_W-1:0] GAIN_DIV     = 8'd30;
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = 8'd250;
    localparam logic [DUTY_W-1:0]   DUTY_MIN     = 8'd10;
    localparam logic [DUTY_W-1:0]   DUTY_RESET   = 8'd40;
    localparam logic [RPM_W-1:0]    TARGET_RESET = 14'd750;
    localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(DIV_STEPS - 1);

    // request to the shared serial divider
    typedef struct packed {
        logic                start;
        logic [RPM_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // duty update command
    typedef struct packed {
        logic             update;
        logic             negative;
        logic [RPM_W-1:0] magnitude;
    } duty_cmd_t;

endpackage

/* src/period_rpm_integral_pwm_ctrl.sv */
// Per item: two 14-step serial divisions (speed, then error / 30), then the duty update.
// One item at a time: the single bit-serial divider is used twice per item.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low): duty level 40, target 750 rpm, no result pending.
// The configuration port is always ready.
module period_rpm_integral_pwm_ctrl
    import prpic_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RPM_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PERIOD_W-1:0] s_period_ticks,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DUTY_W-1:0]   m_duty,
    output logic [RPM_W-1:0]    m_measured_rpm
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SPEED = 2'd1;
    localparam logic [1:0] ST_GAIN  = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [RPM_W-1:0]    target_reg;
    logic [RPM_W-1:0]    speed_reg, speed_next;
    logic                neg_reg, neg_next;
    logic [RPM_W-1:0]    step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0]   m_duty_reg;
    logic [RPM_W-1:0]    m_rpm_reg;
    logic                accept;
    logic                out_free;
    logic                div_done;
    logic [RPM_W-1:0]    div_quo;
    logic [RPM_W:0]      err_pos;
    logic [RPM_W:0]      err_neg;
    logic [PERIOD_W-1:0] period_safe;
    logic [DUTY_W-1:0]   duty_new;
    logic [DUTY_W-1:0]   duty_cur;
    div_req_t            div_req;
    duty_cmd_t           duty_cmd;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // zero period counts as one tick
    assign period_safe = (s_period_ticks == '0) ? PERIOD_W'(1) : s_period_ticks;

    // speed error both ways; pick the non-negative one
    assign err_pos = {1'b0, target_reg} - {1'b0, div_quo};
    assign err_neg = {1'b0, div_quo} - {1'b0, target_reg};

    always_comb begin
        state_next   = state_reg;
        speed_next   = speed_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        div_req      = '0;
        duty_cmd     = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                // start speed division on an accepted item
                if (accept) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = SPEED_NUM;
                    div_req.divisor  = period_safe;
                    state_next       = ST_SPEED;
                end
            end
            ST_SPEED: begin
                // hold speed, start error / 30 on magnitude
                if (div_done) begin
                    speed_next    = div_quo;
                    neg_next      = err_pos[RPM_W];
                    div_req.start = 1'b1;
                    div_req.divisor = GAIN_DIV;
                    if (err_pos[RPM_W]) begin
                        div_req.dividend = err_neg[RPM_W-1:0];
                    end else begin
                        div_req.dividend = err_pos[RPM_W-1:0];
                    end
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (div_done) begin
                    step_next  = div_quo;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                // commit duty once the output register is free
                if (out_free) begin
                    duty_cmd.update    = 1'b1;
                    duty_cmd.negative  = neg_reg;
                    duty_cmd.magnitude = step_reg;
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            target_reg  <= TARGET_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
        end
        speed_reg <= speed_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
        if (duty_cmd.update) begin
            m_duty_reg <= duty_new;
            m_rpm_reg  <= speed_reg;
        end
    end

    prpic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    prpic_duty u_duty (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (duty_cmd),
        .duty_next_val (duty_new),
        .duty          (duty_cur)
    );

    assign m_valid        = m_valid_reg;
    assign m_duty         = (duty_cur == m_duty_reg) ? duty_cur : m_duty_reg;
    assign m_measured_rpm = m_rpm_reg;

endmodule

/* src/prpic_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
module prpic_div
    import prpic_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             done,
    output logic [RPM_W-1:0] quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [RPM_W-1:0]    quo_reg, quo_next;
    logic [PERIOD_W-1:0] dvs_reg, dvs_next;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W+1:0] diff;

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[RPM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            // load a new division
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // advance one quotient bit
            if (!diff[PERIOD_W+1]) begin
                rem_next = diff[PERIOD_W-1:0];
                quo_next = {quo_reg[RPM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[PERIOD_W-1:0];
                quo_next = {quo_reg[RPM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/prpic_duty.sv */
// Kept PWM duty level with integral update and saturation to 10..250.
module prpic_duty
    import prpic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  duty_cmd_t         cmd,
    output logic [DUTY_W-1:0] duty_next_val,
    output logic [DUTY_W-1:0] duty
);

    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic signed [RPM_W+1:0] sum;

    // add or subtract the step, then saturate
    always_comb begin
        if (cmd.negative) begin
            sum = $signed({{(RPM_W-DUTY_W+2){1'b0}}, duty_reg})
                - $signed({2'b00, cmd.magnitude});
        end else begin
            sum = $signed({{(RPM_W-DUTY_W+2){1'b0}}, duty_reg})
                + $signed({2'b00, cmd.magnitude});
        end
        if (sum > $signed({{(RPM_W-DUTY_W+2){1'b0}}, DUTY_MAX})) begin
            duty_next = DUTY_MAX;
        end else if (sum < $signed({{(RPM_W-DUTY_W+2){1'b0}}, DUTY_MIN})) begin
            duty_next = DUTY_MIN;
        end else begin
            duty_next = sum[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= DUTY_RESET;
        end else if (cmd.update) begin
            duty_reg <= duty_next;
        end
    end

    assign duty_next_val = duty_next;
    assign duty          = duty_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the period-to-rpm integral PWM controller.
module testbench;
    import prpic_pkg::*;

    // one expected result: duty after the update and the measured speed
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [RPM_W-1:0]  rpm;
    } duty_result_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RPM_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [PERIOD_W-1:0] s_period_ticks = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [DUTY_W-1:0]   m_duty;
    logic [RPM_W-1:0]    m_measured_rpm;

    // predictor state, mirrors the block after reset
    logic [DUTY_W-1:0] duty_lvl   = DUTY_RESET;
    logic [RPM_W-1:0]  target_set = TARGET_RESET;
    duty_result_t      duty_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int errors         = 0;

    period_rpm_integral_pwm_ctrl i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_period_ticks (s_period_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty         (m_duty),
        .m_measured_rpm (m_measured_rpm)
    );

    // 4-unit clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // compute speed, apply the integral step and saturate the kept duty
    function automatic void advance_duty(input logic [PERIOD_W-1:0] period);
        int speed;
        int rpm_err;
        int next;
        duty_result_t r;
        speed   = int'(SPEED_NUM) / ((period == 0) ? 1 : int'(period));
        rpm_err = int'(target_set) - speed;
        next    = int'(duty_lvl) + rpm_err / int'(GAIN_DIV);
        if (next > int'(DUTY_MAX)) next = int'(DUTY_MAX);
        if (next < int'(DUTY_MIN)) next = int'(DUTY_MIN);
        duty_lvl = DUTY_W'(next);
        r.duty   = duty_lvl;
        r.rpm    = RPM_W'(speed);
        duty_q.push_back(r);
    endfunction

    // offer one item, hold it until accepted, then record its expectation
    task automatic send_period(input logic [PERIOD_W-1:0] period);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_period_ticks <= period;
        do @(posedge aclk); while (!s_ready);
        advance_duty(period);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain;
        s_valid <= 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
    endtask

    // write the target register while the block is idle
    task automatic write_target(input logic [RPM_W-1:0] rpm);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= rpm;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        target_set = rpm;
    endtask

    // mostly periods near the one that matches the target, so duty moves both ways
    function automatic logic [PERIOD_W-1:0] pick_period();
        int sel;
        int center;
        sel = $urandom_range(99);
        if (sel < 10) return PERIOD_W'($urandom_range(0, 3));
        if (sel < 40) return PERIOD_W'($urandom_range(0, 255));
        center = (target_set < 55) ? 255 : 14000 / int'(target_set);
        center = center + $urandom_range(0, 16) - 8;
        if (center < 0) center = 0;
        if (center > 255) center = 255;
        return PERIOD_W'(center);
    endfunction

    // reset target and duty, field extremes
    task automatic test_reset_values;
        send_period(8'd18);
        send_period(8'd255);
        send_period(8'd0);
        send_period(8'd1);
        send_period(8'd2);
        send_period(8'd128);
        send_period(8'd85);
    endtask

    // zero target drives duty to the floor, zero period gives full speed
    task automatic test_duty_floor;
        write_target('0);
        send_period(8'd0);
        send_period(8'd255);
        send_period(8'd1);
    endtask

    // target beyond the speed range drives duty to the ceiling
    task automatic test_duty_ceiling;
        write_target({RPM_W{1'b1}});
        send_period(8'd255);
        send_period(8'd0);
        send_period(8'd254);
        send_period(8'd127);
    endtask

    // target at the top of the speed range, zero error at period one
    task automatic test_target_max;
        write_target(14'd14000);
        send_period(8'd0);
        send_period(8'd1);
        send_period(8'd2);
    endtask

    // random items in one idling pattern at one target
    task automatic run_traffic(input logic [RPM_W-1:0] rpm, input int count,
                               input int send_pct, input int recv_pct);
        write_target(rpm);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_period(pick_period());
        drain();
    endtask

    task automatic test_random_traffic;
        run_traffic(TARGET_RESET, 480, 0, 0);
        run_traffic(RPM_W'($urandom_range(100, 2000)), 480, 81, 0);
        run_traffic(RPM_W'($urandom_range(0, 16383)), 480, 0, 81);
        run_traffic(RPM_W'($urandom_range(300, 6000)), 480, 6, 6);
    endtask

    // hold the result side off while items keep coming, so the input stalls
    task automatic test_output_backpressure;
        write_target(RPM_W'($urandom_range(200, 3000)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        repeat (24) send_period(pick_period());
        drain();
    endtask

    // receiver: long hold when asked, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        duty_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_q.size() == 0) begin
                $display("%0t: unexpected result, duty %0d rpm %0d",
                         $time, m_duty, m_measured_rpm);
                errors++;
            end else begin
                want = duty_q.pop_front();
                if (m_duty !== want.duty) begin
                    $display("%0t: duty mismatch, expected %0d, actual %0d",
                             $time, want.duty, m_duty);
                    errors++;
                end
                if (m_measured_rpm !== want.rpm) begin
                    $display("%0t: rpm mismatch, expected %0d, actual %0d",
                             $time, want.rpm, m_measured_rpm);
                    errors++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_duty_floor();
        test_duty_ceiling();
        test_target_max();
        test_output_backpressure();
        test_random_traffic();
        drain();
        repeat (40) @(posedge aclk);
        if (duty_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // give up on a hung run
    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/prpic_pkg.sv
src/prpic_div.sv
src/prpic_duty.sv
src/period_rpm_integral_pwm_ctrl.sv
dv/testbench.sv
